// File: rtl/bmpsd_pkg.sv
package bmpsd_pkg;

  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;
  localparam int QUEUE_DEPTH    = 4;

  localparam int HEADER_BYTES = 54;
  localparam int FILE_HDR     = 14;
  localparam int MIN_DIB      = 40;
  localparam int OFS_SIG0     = 0;
  localparam int OFS_SIG1     = 1;
  localparam int OFS_PIXEL    = 10;
  localparam int OFS_DIB      = 14;
  localparam int OFS_WIDTH    = 18;
  localparam int OFS_HEIGHT   = 22;
  localparam int OFS_PLANES   = 26;
  localparam int OFS_BPP      = 28;
  localparam int OFS_COMP     = 30;
  localparam int STEP_STRIDE  = 29;
  localparam int STEP_PROD_LO = 30;
  localparam int STEP_PROD_HI = 31;
  localparam int STEP_END     = 32;

  localparam logic [7:0] SIG_B   = 8'h42;
  localparam logic [7:0] SIG_M   = 8'h4D;
  localparam logic [7:0] BPP_24  = 8'd24;
  localparam logic [7:0] BPP_32  = 8'd32;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_NOT_BMP     = 3'd1;
  localparam logic [2:0] ST_BAD_HEADER  = 3'd2;
  localparam logic [2:0] ST_UNSUPPORTED = 3'd3;
  localparam logic [2:0] ST_TRUNCATED   = 3'd4;
  localparam logic [2:0] ST_TOO_LARGE   = 3'd5;

  localparam int F_NOT_BMP     = 0;
  localparam int F_BAD_HEADER  = 1;
  localparam int F_UNSUPPORTED = 2;
  localparam int F_TRUNCATED   = 3;
  localparam int F_TOO_LARGE   = 4;

  typedef struct packed {
    logic        has_pixel;
    logic        has_status;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [11:0] column;
    logic [11:0] out_row;
    logic [2:0]  code;
    logic [12:0] width;
    logic [12:0] height;
  } entry_t;

endpackage

// File: rtl/bmp_stream_decoder.sv
// Streaming decoder for uncompressed 24/32-bit bitmap files.
// Input channel: one file byte per transfer (file_byte), end_of_file set on
// the final byte of a file. Output channel: pixel items (is_status 0) with
// red, green, blue, column and out_row, then one status item (is_status 1,
// last 1) per file carrying status_code, image_width and image_height.
// Pixels stream before the status; drop them when the status is not ok.
// Throughput: one byte per cycle while the queue has room. A byte that ends
// a pixel and the file together yields two items, which leave as two transfers.
// A result shows on the output once the output side is free: classification
// and queue write in the transfer cycle, then a queue read into the output
// register.
// A four-entry queue separates the byte classifier from the output stage;
// in_ready drops only when that queue is full, so the output side may stall
// while input transfers go on until the queue fills.
// Reset (synchronous, rst high) clears the decoder to the start of a file and
// empties the queue. After the status item the decoder expects a new file.
// Header arithmetic for the truncation check is spread over header bytes
// 29 to 32: stride, two partial products, then the body end sum.
module bmp_stream_decoder import bmpsd_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  file_byte,
  input  logic        end_of_file,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        is_status,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic [11:0] column,
  output logic [11:0] out_row,
  output logic [2:0]  status_code,
  output logic [12:0] image_width,
  output logic [12:0] image_height,
  output logic        last
);

  logic   take;
  logic   push;
  entry_t push_data;
  entry_t q_data;
  logic   q_full;
  logic   q_empty;
  logic   q_pop;

  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;

  bmpsd_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .file_byte  (file_byte),
    .end_of_file(end_of_file),
    .push       (push),
    .entry      (push_data)
  );

  bmpsd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .pop      (q_pop),
    .pop_data (q_data),
    .full     (q_full),
    .empty    (q_empty)
  );

  bmpsd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_data      (q_data),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .is_status   (is_status),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .column      (column),
    .out_row     (out_row),
    .status_code (status_code),
    .image_width (image_width),
    .image_height(image_height),
    .last        (last)
  );

endmodule

// File: rtl/bmpsd_front.sv
module bmpsd_front import bmpsd_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] file_byte,
  input  logic       end_of_file,
  output logic       push,
  output entry_t     entry
);

  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 1);
  localparam int BW = $clog2(4 * MAX_WIDTH + 4);

  logic [31:0]   pos, pos_next;
  logic [31:0]   pixel_start, pixel_start_next;
  logic [31:0]   header_size, header_size_next;
  logic [31:0]   width_seen, width_seen_next;
  logic [31:0]   height_seen, height_seen_next;
  logic [31:0]   habs, habs_next;
  logic [2:0]    bpp, bpp_next;
  logic [4:0]    err, err_next;
  logic [1:0]    bip, bip_next;
  logic [CW-1:0] col, col_next;
  logic [RW-1:0] frow, frow_next;
  logic [BW-1:0] rbc, rbc_next;
  logic [7:0]    held_blue, held_blue_next;
  logic [7:0]    held_green, held_green_next;
  logic [34:0]   stride, stride_next;
  logic [34:0]   dlen, dlen_next;
  logic [66:0]   prod, prod_next;
  logic [67:0]   body_end, body_end_next;

  logic [5:0]  p;
  logic [1:0]  lane;
  logic [31:0] h_abs_new;
  logic [34:0] wb;
  logic [50:0] part;
  logic [4:0]  flags;
  logic [2:0]  code;

  always_comb begin
    pos_next         = (pos == 32'hFFFF_FFFF) ? pos : pos + 32'd1;
    pixel_start_next = pixel_start;
    header_size_next = header_size;
    width_seen_next  = width_seen;
    height_seen_next = height_seen;
    habs_next        = habs;
    bpp_next         = bpp;
    err_next         = err;
    bip_next         = bip;
    col_next         = col;
    frow_next        = frow;
    rbc_next         = rbc;
    held_blue_next   = held_blue;
    held_green_next  = held_green;
    stride_next      = stride;
    dlen_next        = dlen;
    prod_next        = prod;
    body_end_next    = body_end;
    entry            = '0;
    p                = pos[5:0];
    lane             = '0;
    h_abs_new        = '0;
    wb               = '0;
    part             = '0;
    flags            = '0;
    code             = ST_OK;

    if (pos < 32'(HEADER_BYTES)) begin
      if (p == 6'(OFS_SIG0) && file_byte != SIG_B) err_next[F_NOT_BMP] = 1'b1;
      if (p == 6'(OFS_SIG1) && file_byte != SIG_M) err_next[F_NOT_BMP] = 1'b1;
      if (p >= 6'(OFS_PIXEL) && p < 6'(OFS_PIXEL + 4)) begin
        lane = 2'(p - 6'(OFS_PIXEL));
        pixel_start_next[{lane, 3'b000} +: 8] = file_byte;
      end
      if (p >= 6'(OFS_DIB) && p < 6'(OFS_DIB + 4)) begin
        lane = 2'(p - 6'(OFS_DIB));
        header_size_next[{lane, 3'b000} +: 8] = file_byte;
      end
      if (p >= 6'(OFS_WIDTH) && p < 6'(OFS_WIDTH + 4)) begin
        lane = 2'(p - 6'(OFS_WIDTH));
        width_seen_next[{lane, 3'b000} +: 8] = file_byte;
      end
      if (p >= 6'(OFS_HEIGHT) && p < 6'(OFS_HEIGHT + 4)) begin
        lane = 2'(p - 6'(OFS_HEIGHT));
        height_seen_next[{lane, 3'b000} +: 8] = file_byte;
      end
      if (p == 6'(OFS_DIB + 3)) begin
        if (header_size_next < 32'(MIN_DIB) ||
            {1'b0, pixel_start} < 33'(FILE_HDR) + {1'b0, header_size_next})
          err_next[F_BAD_HEADER] = 1'b1;
      end
      if (p == 6'(OFS_HEIGHT + 3)) begin
        h_abs_new = height_seen_next[31] ? 32'd0 - height_seen_next : height_seen_next;
        habs_next = h_abs_new;
        if (width_seen == 32'd0 || width_seen[31] || height_seen_next == 32'd0)
          err_next[F_UNSUPPORTED] = 1'b1;
        else if (width_seen > 32'(MAX_WIDTH) || h_abs_new > 32'(MAX_HEIGHT))
          err_next[F_TOO_LARGE] = 1'b1;
      end
      if (p == 6'(OFS_PLANES) && file_byte != 8'd1) err_next[F_UNSUPPORTED] = 1'b1;
      if (p == 6'(OFS_PLANES + 1) && file_byte != 8'd0) err_next[F_UNSUPPORTED] = 1'b1;
      if (p == 6'(OFS_BPP)) begin
        if (file_byte == BPP_24) bpp_next = 3'd3;
        else if (file_byte == BPP_32) bpp_next = 3'd4;
        else begin
          bpp_next = 3'd0;
          err_next[F_UNSUPPORTED] = 1'b1;
        end
      end
      if (p == 6'(OFS_BPP + 1) && file_byte != 8'd0) err_next[F_UNSUPPORTED] = 1'b1;
      if (p >= 6'(OFS_COMP) && p < 6'(OFS_COMP + 4) && file_byte != 8'd0)
        err_next[F_UNSUPPORTED] = 1'b1;
      if (p == 6'(STEP_STRIDE)) begin
        wb          = {3'b000, width_seen} * {32'd0, bpp};
        dlen_next   = wb;
        stride_next = (wb + 35'd3) & ~35'd3;
      end
      if (p == 6'(STEP_PROD_LO)) begin
        part      = {16'd0, stride} * {35'd0, habs[15:0]};
        prod_next = {16'd0, part};
      end
      if (p == 6'(STEP_PROD_HI)) begin
        part      = {16'd0, stride} * {35'd0, habs[31:16]};
        prod_next = prod + {part, 16'd0};
      end
      if (p == 6'(STEP_END)) body_end_next = {1'b0, prod} + 68'(pixel_start);
    end else if (pos >= pixel_start && err == 5'd0 && bpp != 3'd0 &&
                 32'(frow) < habs) begin
      if (35'(rbc) < dlen) begin
        if (bip == 2'd0) held_blue_next = file_byte;
        else if (bip == 2'd1) held_green_next = file_byte;
        else if (bip == 2'd2) begin
          entry.has_pixel = 1'b1;
          entry.red       = file_byte;
          entry.green     = held_green;
          entry.blue      = held_blue;
          entry.column    = 12'(col);
          entry.out_row   = height_seen[31] ? 12'(frow) : 12'(habs - 32'd1 - 32'(frow));
        end
        if (3'(bip) + 3'd1 >= bpp) begin
          bip_next = '0;
          col_next = col + CW'(1);
        end else begin
          bip_next = bip + 2'd1;
        end
      end
      if (35'(rbc) + 35'd1 >= stride) begin
        rbc_next  = '0;
        col_next  = '0;
        bip_next  = '0;
        frow_next = frow + RW'(1);
      end else begin
        rbc_next = rbc + BW'(1);
      end
    end

    if (end_of_file) begin
      flags = err_next;
      if (pos_next < 32'(HEADER_BYTES)) flags[F_NOT_BMP] = 1'b1;
      if ({1'b0, pos_next} < 33'(FILE_HDR) + {1'b0, header_size_next})
        flags[F_BAD_HEADER] = 1'b1;
      if (habs != 32'd0 && body_end > 68'(pos_next)) flags[F_TRUNCATED] = 1'b1;
      if (flags[F_NOT_BMP]) code = ST_NOT_BMP;
      else if (flags[F_BAD_HEADER]) code = ST_BAD_HEADER;
      else if (flags[F_UNSUPPORTED]) code = ST_UNSUPPORTED;
      else if (flags[F_TRUNCATED]) code = ST_TRUNCATED;
      else if (flags[F_TOO_LARGE]) code = ST_TOO_LARGE;
      else code = ST_OK;
      entry.has_status = 1'b1;
      entry.code       = code;
      entry.width      = (code == ST_OK) ? 13'(width_seen) : 13'd0;
      entry.height     = (code == ST_OK) ? 13'(habs) : 13'd0;
      pos_next         = '0;
      pixel_start_next = '0;
      header_size_next = '0;
      width_seen_next  = '0;
      height_seen_next = '0;
      habs_next        = '0;
      bpp_next         = '0;
      err_next         = '0;
      bip_next         = '0;
      col_next         = '0;
      frow_next        = '0;
      rbc_next         = '0;
      held_blue_next   = '0;
      held_green_next  = '0;
      stride_next      = '0;
      dlen_next        = '0;
      prod_next        = '0;
      body_end_next    = '0;
    end
  end

  assign push = take && (entry.has_pixel || entry.has_status);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= '0;
      pixel_start <= '0;
      header_size <= '0;
      width_seen  <= '0;
      height_seen <= '0;
      habs        <= '0;
      bpp         <= '0;
      err         <= '0;
      bip         <= '0;
      col         <= '0;
      frow        <= '0;
      rbc         <= '0;
      held_blue   <= '0;
      held_green  <= '0;
      stride      <= '0;
      dlen        <= '0;
      prod        <= '0;
      body_end    <= '0;
    end else if (take) begin
      pos         <= pos_next;
      pixel_start <= pixel_start_next;
      header_size <= header_size_next;
      width_seen  <= width_seen_next;
      height_seen <= height_seen_next;
      habs        <= habs_next;
      bpp         <= bpp_next;
      err         <= err_next;
      bip         <= bip_next;
      col         <= col_next;
      frow        <= frow_next;
      rbc         <= rbc_next;
      held_blue   <= held_blue_next;
      held_green  <= held_green_next;
      stride      <= stride_next;
      dlen        <= dlen_next;
      prod        <= prod_next;
      body_end    <= body_end_next;
    end
  end

endmodule

// File: rtl/bmpsd_queue.sv
module bmpsd_queue import bmpsd_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_data,
  input  logic   pop,
  output entry_t pop_data,
  output logic   full,
  output logic   empty
);

  localparam int AW = $clog2(QUEUE_DEPTH);

  entry_t          mem [QUEUE_DEPTH];
  logic [AW-1:0]   wptr;
  logic [AW-1:0]   rptr;
  logic [AW:0]     count;

  assign full     = (count == (AW+1)'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + AW'(1);
      if (pop) rptr <= rptr + AW'(1);
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

endmodule

// File: rtl/bmpsd_back.sv
module bmpsd_back import bmpsd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  entry_t      q_data,
  input  logic        q_empty,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        is_status,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic [11:0] column,
  output logic [11:0] out_row,
  output logic [2:0]  status_code,
  output logic [12:0] image_width,
  output logic [12:0] image_height,
  output logic        last
);

  entry_t cur;
  logic   cur_valid;
  logic   xfer;
  logic   finish;
  logic   load;
  logic   pix;

  assign pix    = cur.has_pixel;
  assign xfer   = cur_valid && out_ready;
  assign finish = xfer && !(cur.has_pixel && cur.has_status);
  assign load   = !cur_valid || finish;
  assign q_pop  = load && !q_empty;

  assign out_valid    = cur_valid;
  assign is_status    = !pix;
  assign red          = pix ? cur.red : 8'd0;
  assign green        = pix ? cur.green : 8'd0;
  assign blue         = pix ? cur.blue : 8'd0;
  assign column       = pix ? cur.column : 12'd0;
  assign out_row      = pix ? cur.out_row : 12'd0;
  assign status_code  = pix ? ST_OK : cur.code;
  assign image_width  = pix ? 13'd0 : cur.width;
  assign image_height = pix ? 13'd0 : cur.height;
  assign last         = !pix;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
    end else if (load) begin
      cur_valid <= !q_empty;
      cur       <= q_data;
    end else if (xfer) begin
      cur.has_pixel <= 1'b0;
    end
  end

endmodule

// File: rtl/bmpsd_checker.sv
module bmpsd_checker import bmpsd_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        is_status,
  input logic [7:0]  red,
  input logic [11:0] column,
  input logic [2:0]  status_code,
  input logic        last
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output valid dropped during stall");

  a_last_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last == is_status))
    else $error("last does not match status item");

  a_pixel_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_status |-> (status_code == ST_OK))
    else $error("pixel item carries a status code");

  a_status_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_status |-> (red == 8'd0 && column == 12'd0))
    else $error("status item carries pixel data");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind bmp_stream_decoder bmpsd_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .is_status  (is_status),
  .red        (red),
  .column     (column),
  .status_code(status_code),
  .last       (last)
);

// File: sim/bmp_stream_checker.sv
`timescale 1ns / 100ps

module bmp_stream_checker import bmpsd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  file_byte,
  input  logic        end_of_file,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        is_status,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  input  logic [11:0] column,
  input  logic [11:0] out_row,
  input  logic [2:0]  status_code,
  input  logic [12:0] image_width,
  input  logic [12:0] image_height,
  input  logic        last,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic        st;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [11:0] col;
    logic [11:0] row;
    logic [2:0]  code;
    logic [12:0] w;
    logic [12:0] h;
    logic        lst;
  } decoded_t;

  decoded_t decoded_q[$];

  logic [31:0] pos, pix_ofs, dib_size, wid, hgt;
  logic [2:0]  bpp_bytes;
  logic [4:0]  flags;
  logic [1:0]  sub_byte;
  logic [11:0] col_cnt;
  logic [12:0] row_cnt;
  logic [14:0] row_bytes;
  logic [7:0]  keep_b, keep_g;

  assign pending = decoded_q.size();

  task automatic clear_file();
    pos = 0; pix_ofs = 0; dib_size = 0; wid = 0; hgt = 0; bpp_bytes = 0;
    flags = 0; sub_byte = 0; col_cnt = 0; row_cnt = 0; row_bytes = 0;
    keep_b = 0; keep_g = 0;
  endtask

  function automatic logic [31:0] abs_hgt();
    return hgt[31] ? 32'd0 - hgt : hgt;
  endfunction

  task automatic header_byte(input logic [31:0] p, input logic [7:0] b);
    if (p == OFS_SIG0 && b != SIG_B) flags[F_NOT_BMP] = 1;
    if (p == OFS_SIG1 && b != SIG_M) flags[F_NOT_BMP] = 1;
    if (p >= 10 && p <= 13) pix_ofs |= 32'(b) << (8 * (p - 10));
    if (p >= 14 && p <= 17) dib_size |= 32'(b) << (8 * (p - 14));
    if (p >= 18 && p <= 21) wid |= 32'(b) << (8 * (p - 18));
    if (p >= 22 && p <= 25) hgt |= 32'(b) << (8 * (p - 22));
    if (p == 17 && (dib_size < MIN_DIB || 33'(pix_ofs) < 33'(FILE_HDR) + 33'(dib_size)))
      flags[F_BAD_HEADER] = 1;
    if (p == 25) begin
      if (wid == 0 || wid[31] || hgt == 0) flags[F_UNSUPPORTED] = 1;
      else if (wid > DEF_MAX_WIDTH || abs_hgt() > DEF_MAX_HEIGHT) flags[F_TOO_LARGE] = 1;
    end
    if (p == 26 && b != 1) flags[F_UNSUPPORTED] = 1;
    if (p == 27 && b != 0) flags[F_UNSUPPORTED] = 1;
    if (p == OFS_BPP) begin
      if (b == BPP_24) bpp_bytes = 3;
      else if (b == BPP_32) bpp_bytes = 4;
      else begin
        bpp_bytes = 0;
        flags[F_UNSUPPORTED] = 1;
      end
    end
    if (p >= 29 && p <= 33 && b != 0) flags[F_UNSUPPORTED] = 1;
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic eof);
    logic [31:0] h, data_len, stride;
    logic [63:0] len, body, str64;
    logic [2:0] code;
    decoded_t d;
    h = abs_hgt();
    if (pos < HEADER_BYTES) header_byte(pos, b);
    else if (pos >= pix_ofs && flags == 0 && bpp_bytes != 0 && 32'(row_cnt) < h) begin
      data_len = wid * bpp_bytes;
      stride = (data_len + 3) & ~32'd3;
      if (32'(row_bytes) < data_len) begin
        if (sub_byte == 0) keep_b = b;
        else if (sub_byte == 1) keep_g = b;
        else if (sub_byte == 2) begin
          d = '0;
          d.r = b; d.g = keep_g; d.b = keep_b; d.col = col_cnt;
          d.row = hgt[31] ? 12'(row_cnt) : 12'(h - 1 - 32'(row_cnt));
          decoded_q.push_back(d);
        end
        sub_byte++;
        if (sub_byte == 0 || 32'(sub_byte) >= bpp_bytes) begin
          sub_byte = 0;
          col_cnt++;
        end
      end
      row_bytes++;
      if (32'(row_bytes) >= stride) begin
        row_bytes = 0; col_cnt = 0; sub_byte = 0; row_cnt++;
      end
    end
    if (pos != 32'hFFFF_FFFF) pos++;
    if (eof) begin
      len = 64'(pos);
      if (len < HEADER_BYTES) flags[F_NOT_BMP] = 1;
      if (len < 64'(FILE_HDR) + 64'(dib_size)) flags[F_BAD_HEADER] = 1;
      if (h != 0) begin
        str64 = ((64'(wid) * bpp_bytes + 3) / 4) * 4;
        if (str64 > 64'hFFFF_FFFF_FFFF_FFFF / h) flags[F_TRUNCATED] = 1;
        else begin
          body = str64 * h;
          if (body > 64'hFFFF_FFFF_FFFF_FFFF - pix_ofs || pix_ofs + body > len)
            flags[F_TRUNCATED] = 1;
        end
      end
      code = ST_OK;
      for (int k = 4; k >= 0; k--) if (flags[k]) code = 3'(k + 1);
      d = '0;
      d.st = 1; d.lst = 1; d.code = code;
      d.w = code == ST_OK ? 13'(wid) : 13'd0;
      d.h = code == ST_OK ? 13'(h) : 13'd0;
      decoded_q.push_back(d);
      clear_file();
    end
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    clear_file();
  end

  always @(posedge clk) begin
    decoded_t e;
    if (rst) begin
      clear_file();
      decoded_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (decoded_q.size() == 0) report("unexpected transfer", is_status, 0);
        else begin
          e = decoded_q.pop_front();
          if (is_status !== e.st) report("is_status", is_status, e.st);
          if (red !== e.r) report("red", red, e.r);
          if (green !== e.g) report("green", green, e.g);
          if (blue !== e.b) report("blue", blue, e.b);
          if (column !== e.col) report("column", column, e.col);
          if (out_row !== e.row) report("out_row", out_row, e.row);
          if (status_code !== e.code) report("status_code", status_code, e.code);
          if (image_width !== e.w) report("image_width", image_width, e.w);
          if (image_height !== e.h) report("image_height", image_height, e.h);
          if (last !== e.lst) report("last", last, e.lst);
        end
      end
      if (in_valid && in_ready) decode_byte(file_byte, end_of_file);
    end
  end

endmodule

// File: sim/tb_bmp_stream_decoder.sv
`timescale 1ns / 100ps

module tb_bmp_stream_decoder import bmpsd_pkg::*;;

  logic        clk, rst, in_valid, in_ready, end_of_file, out_valid, out_ready;
  logic [7:0]  file_byte, red, green, blue;
  logic [11:0] column, out_row;
  logic [2:0]  status_code;
  logic [12:0] image_width, image_height;
  logic        is_status, last;
  int          fail_count, pending, cycles, sent;
  bit          calm;

  bmp_stream_decoder dut (.*);

  bmp_stream_checker chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 400000) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    int gap;
    out_ready = 0;
    @(negedge clk);
    forever begin
      if (!calm && $urandom_range(3) == 0) begin
        gap = $urandom_range(1, 6);
        out_ready = 0;
        repeat (gap) @(negedge clk);
      end
      out_ready = 1;
      @(negedge clk);
    end
  end

  task automatic send(input logic [7:0] b, input logic eof);
    if (!calm && $urandom_range(5) == 0) begin
      in_valid = 0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid = 1;
    file_byte = b;
    end_of_file = eof;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    in_valid = 0;
    sent++;
  endtask

  task automatic send_word(input logic [31:0] v, input int n);
    for (int i = 0; i < n; i++) send(v[8*i +: 8], 0);
  endtask

  // build a file; the mode value corrupts one individual header part
  task automatic send_file(input int w, input int h, input bit bpp32, input int extra,
                           input int cut, input int mode);
    logic [31:0] ofs, dib, stride, total, hraw, bodylen;
    int n;
    dib = (mode == 2) ? 32'd39 : 32'd40;
    ofs = 54 + extra;
    if (mode == 3) ofs = 50;
    stride = ((w * (bpp32 ? 4 : 3)) + 3) & ~3;
    hraw = h;
    bodylen = stride * (h < 0 ? -h : h);
    total = ofs + bodylen - cut;
    if (total < 54) total = 54;
    n = 0;
    send(mode == 1 ? 8'h41 : SIG_B, 0); send(SIG_M, 0); n = 2;
    send_word(total, 4); send_word(0, 4); send_word(ofs, 4);
    send_word(dib, 4); send_word(w, 4); send_word(hraw, 4);
    send_word(mode == 4 ? 2 : 1, 2);
    send_word(mode == 5 ? 16 : (bpp32 ? 32 : 24), 2);
    send_word(mode == 6 ? 1 : 0, 4);
    n = 34;
    while (n < total - 1) begin
      send(n >= ofs ? 8'($urandom) : 8'($urandom_range(0, 255)), 0);
      n++;
    end
    send(8'($urandom), 1);
  endtask

  task automatic send_noise(input int n);
    for (int i = 0; i < n - 1; i++) send(8'($urandom), 0);
    send(8'($urandom), 1);
  endtask

  initial begin
    int r;
    rst = 1; in_valid = 0; file_byte = 0; end_of_file = 0; calm = 0; sent = 0;
    repeat (6) @(negedge clk);
    rst = 0;
    send(8'hFF, 1);
    send_noise(20);
    send_file(2, -2, 1, 3, 0, 0);
    send_file(1, 1, 0, 0, 0, 3);
    send_file(0, 1, 0, 0, 0, 0);
    send_file(1, -4097, 0, 0, 16380, 0);
    send_file(3, 2, 0, 0, 5, 0);
    while (sent < 450) begin
      if (sent > 380) calm = 1;
      r = $urandom_range(9);
      if (r == 0) send_noise($urandom_range(1, 70));
      else if (r == 1) send_file($urandom_range(1, 4), $urandom_range(1, 3), $urandom_range(1),
                                 0, 0, $urandom_range(1, 6));
      else send_file($urandom_range(1, 5),
                     $urandom_range(1) ? $urandom_range(1, 4) : -$urandom_range(1, 4),
                     $urandom_range(1), $urandom_range(0, 4),
                     $urandom_range(4) == 0 ? $urandom_range(1, 8) : 0, 0);
    end
    calm = 1;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
